// ----- rtl/qru_pkg.sv -----
// Shared types and constants for the quaternion rotation unit pipeline.
package qru_pkg;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_ROT  = 2'd1,
    OP_AXES = 2'd2
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } qru_ctl_t;

  localparam int unsigned NPROD = 16;
  localparam int unsigned NRES  = 9;
  localparam int unsigned NROT  = 9;

  localparam int unsigned QW = 0;
  localparam int unsigned QX = 1;
  localparam int unsigned QY = 2;
  localparam int unsigned QZ = 3;

  localparam int unsigned VX = 0;
  localparam int unsigned VY = 1;
  localparam int unsigned VZ = 2;

  function automatic int unsigned sum_width(input int unsigned cw, input int unsigned fb);
    return ((2 * cw > fb + 1) ? 2 * cw : fb + 1) + 4;
  endfunction

endpackage

// ----- rtl/qru_prod.sv -----
// First pipeline stage: operand selection and the sixteen first-level products.
module qru_prod import qru_pkg::*; #(
  parameter int unsigned CW = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  qru_ctl_t             ctl_in,
  input  logic signed [CW-1:0] av_in [4],
  input  logic signed [CW-1:0] b_w,
  input  logic signed [CW-1:0] bv_in [3],
  output qru_ctl_t             ctl,
  output logic signed [2*CW-1:0] prod [NPROD],
  output logic signed [CW-1:0] av [4],
  output logic signed [CW-1:0] bv [3]
);

  logic signed [CW-1:0] ma [NPROD];
  logic signed [CW-1:0] mb [NPROD];
  logic signed [CW-1:0] aw, ax, ay, az, bx, by, bz;

  assign aw = av_in[QW];
  assign ax = av_in[QX];
  assign ay = av_in[QY];
  assign az = av_in[QZ];
  assign bx = bv_in[VX];
  assign by = bv_in[VY];
  assign bz = bv_in[VZ];

  always_comb begin
    for (int i = 0; i < NPROD; i++) begin
      ma[i] = '0;
      mb[i] = '0;
    end
    case (ctl_in.op)
      OP_MUL: begin
        ma[0]  = ay;  mb[0]  = bz;
        ma[1]  = az;  mb[1]  = by;
        ma[2]  = aw;  mb[2]  = bx;
        ma[3]  = b_w; mb[3]  = ax;
        ma[4]  = az;  mb[4]  = bx;
        ma[5]  = ax;  mb[5]  = bz;
        ma[6]  = aw;  mb[6]  = by;
        ma[7]  = b_w; mb[7]  = ay;
        ma[8]  = ax;  mb[8]  = by;
        ma[9]  = ay;  mb[9]  = bx;
        ma[10] = aw;  mb[10] = bz;
        ma[11] = b_w; mb[11] = az;
        ma[12] = aw;  mb[12] = b_w;
        ma[13] = ax;  mb[13] = bx;
        ma[14] = ay;  mb[14] = by;
        ma[15] = az;  mb[15] = bz;
      end
      OP_ROT: begin
        ma[0]  = by;  mb[0]  = az;
        ma[1]  = bz;  mb[1]  = ay;
        ma[2]  = bx;  mb[2]  = ax;
        ma[4]  = bz;  mb[4]  = ax;
        ma[5]  = bx;  mb[5]  = az;
        ma[6]  = by;  mb[6]  = ay;
        ma[8]  = bx;  mb[8]  = ay;
        ma[9]  = by;  mb[9]  = ax;
        ma[10] = bz;  mb[10] = az;
        ma[12] = aw;  mb[12] = aw;
        ma[13] = ax;  mb[13] = ax;
        ma[14] = ay;  mb[14] = ay;
        ma[15] = az;  mb[15] = az;
      end
      OP_AXES: begin
        ma[0]  = ax;  mb[0]  = ay;
        ma[1]  = ax;  mb[1]  = az;
        ma[2]  = ay;  mb[2]  = az;
        ma[4]  = aw;  mb[4]  = ax;
        ma[5]  = aw;  mb[5]  = ay;
        ma[6]  = aw;  mb[6]  = az;
        ma[13] = ax;  mb[13] = ax;
        ma[14] = ay;  mb[14] = ay;
        ma[15] = az;  mb[15] = az;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NPROD; i++) begin
        prod[i] <= ma[i] * mb[i];
      end
      av <= av_in;
      bv <= bv_in;
    end
  end

endmodule

// ----- rtl/qru_sum.sv -----
// Second pipeline stage: rounding, sums and saturation of the first-level terms.
module qru_sum import qru_pkg::*; #(
  parameter int unsigned CW = 16,
  parameter int unsigned FB = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  qru_ctl_t               ctl_in,
  input  logic signed [2*CW-1:0] prod [NPROD],
  input  logic signed [CW-1:0]   av_in [4],
  input  logic signed [CW-1:0]   bv_in [3],
  output qru_ctl_t               ctl,
  output logic signed [CW-1:0]   res [NRES],
  output logic                   clip,
  output logic signed [CW-1:0]   av [4],
  output logic signed [CW-1:0]   bv [3]
);

  localparam int unsigned PW = 2 * CW;
  localparam int unsigned SW = sum_width(CW, FB);
  localparam logic signed [SW-1:0] HALF = SW'(1) << (FB - 1);
  localparam logic signed [SW-1:0] CMAX = {{(SW - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
  localparam logic signed [SW-1:0] CMIN = ~CMAX;
  localparam logic signed [SW-1:0] ONE  = SW'(1) << FB;

  function automatic logic signed [SW-1:0] rnd(input logic signed [PW-1:0] p);
    logic signed [SW-1:0] t;
    t = SW'(p) + HALF;
    return t >>> FB;
  endfunction

  function automatic logic signed [CW-1:0] sat(input logic signed [SW-1:0] v);
    if (v > CMAX) begin
      return CMAX[CW-1:0];
    end else if (v < CMIN) begin
      return CMIN[CW-1:0];
    end
    return v[CW-1:0];
  endfunction

  logic signed [SW-1:0] rp  [NPROD];
  logic signed [SW-1:0] dbl [NPROD];
  logic signed [SW-1:0] w   [NRES];
  logic signed [CW-1:0] sv  [NRES];
  logic                 clip_next;

  always_comb begin
    for (int i = 0; i < NPROD; i++) begin
      rp[i]  = rnd(prod[i]);
      dbl[i] = rp[i] <<< 1;
    end
    for (int i = 0; i < NRES; i++) begin
      w[i] = '0;
    end
    case (ctl_in.op)
      OP_MUL: begin
        w[0] = rp[0] - rp[1] + rp[2] + rp[3];
        w[1] = rp[4] - rp[5] + rp[6] + rp[7];
        w[2] = rp[8] - rp[9] + rp[10] + rp[11];
        w[3] = rp[12] - rp[13] - rp[14] - rp[15];
      end
      OP_ROT: begin
        w[0] = rp[12] - rp[13] - rp[14] - rp[15];
        w[1] = rp[2] + rp[6] + rp[10];
        w[2] = rp[0] - rp[1];
        w[3] = rp[4] - rp[5];
        w[4] = rp[8] - rp[9];
      end
      OP_AXES: begin
        w[0] = ONE - dbl[14] - dbl[15];
        w[1] = dbl[0] + dbl[6];
        w[2] = dbl[1] - dbl[5];
        w[3] = dbl[0] - dbl[6];
        w[4] = ONE - dbl[13] - dbl[15];
        w[5] = dbl[2] + dbl[4];
        w[6] = dbl[1] + dbl[5];
        w[7] = dbl[2] - dbl[4];
        w[8] = ONE - dbl[13] - dbl[14];
      end
      default: begin
      end
    endcase
    clip_next = 1'b0;
    for (int i = 0; i < NRES; i++) begin
      sv[i]     = sat(w[i]);
      clip_next = clip_next | (w[i] > CMAX) | (w[i] < CMIN);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res  <= sv;
      clip <= clip_next;
      av   <= av_in;
      bv   <= bv_in;
    end
  end

endmodule

// ----- rtl/qru_rot.sv -----
// Third pipeline stage: second-level products of the vector rotation.
module qru_rot import qru_pkg::*; #(
  parameter int unsigned CW = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  qru_ctl_t               ctl_in,
  input  logic signed [CW-1:0]   res_in [NRES],
  input  logic                   clip_in,
  input  logic signed [CW-1:0]   av_in [4],
  input  logic signed [CW-1:0]   bv_in [3],
  output qru_ctl_t               ctl,
  output logic signed [CW-1:0]   res [NRES],
  output logic                   clip,
  output logic signed [2*CW-1:0] rprod [NROT]
);

  logic signed [CW-1:0] s, d, cx, cy, cz;

  assign s  = res_in[0];
  assign d  = res_in[1];
  assign cx = res_in[2];
  assign cy = res_in[3];
  assign cz = res_in[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rprod[0] <= bv_in[VX] * s;
      rprod[1] <= bv_in[VY] * s;
      rprod[2] <= bv_in[VZ] * s;
      rprod[3] <= av_in[QX] * d;
      rprod[4] <= av_in[QY] * d;
      rprod[5] <= av_in[QZ] * d;
      rprod[6] <= cx * av_in[QW];
      rprod[7] <= cy * av_in[QW];
      rprod[8] <= cz * av_in[QW];
      res      <= res_in;
      clip     <= clip_in;
    end
  end

endmodule

// ----- rtl/qru_final.sv -----
// Fourth pipeline stage: rotation combine, saturation and the output register.
module qru_final import qru_pkg::*; #(
  parameter int unsigned CW = 16,
  parameter int unsigned FB = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  qru_ctl_t               ctl_in,
  input  logic signed [CW-1:0]   res_in [NRES],
  input  logic                   clip_in,
  input  logic signed [2*CW-1:0] rprod [NROT],
  output qru_ctl_t               ctl,
  output logic signed [CW-1:0]   res [NRES],
  output logic                   clip
);

  localparam int unsigned PW = 2 * CW;
  localparam int unsigned SW = sum_width(CW, FB);
  localparam logic signed [SW-1:0] HALF = SW'(1) << (FB - 1);
  localparam logic signed [SW-1:0] CMAX = {{(SW - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
  localparam logic signed [SW-1:0] CMIN = ~CMAX;

  function automatic logic signed [SW-1:0] rnd(input logic signed [PW-1:0] p);
    logic signed [SW-1:0] t;
    t = SW'(p) + HALF;
    return t >>> FB;
  endfunction

  function automatic logic signed [CW-1:0] sat(input logic signed [SW-1:0] v);
    if (v > CMAX) begin
      return CMAX[CW-1:0];
    end else if (v < CMIN) begin
      return CMIN[CW-1:0];
    end
    return v[CW-1:0];
  endfunction

  logic signed [SW-1:0] w [3];
  logic signed [CW-1:0] res_next [NRES];
  logic                 clip_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w[i] = rnd(rprod[i]) + ((rnd(rprod[3 + i]) + rnd(rprod[6 + i])) <<< 1);
    end
    res_next  = res_in;
    clip_next = clip_in;
    case (ctl_in.op)
      OP_ROT: begin
        for (int i = 0; i < NRES; i++) begin
          res_next[i] = '0;
        end
        for (int i = 0; i < 3; i++) begin
          res_next[i] = sat(w[i]);
          clip_next   = clip_next | (w[i] > CMAX) | (w[i] < CMIN);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res  <= res_next;
      clip <= clip_next;
    end
  end

endmodule

// ----- rtl/quaternion_rotation_unit_core.sv -----
// Top level of the quaternion rotation unit: four-stage pipeline and handshake.
// Fixed-point quaternion unit (COMP_WIDTH-bit components, FRAC_BITS fraction
// bits): op 0 gives the Hamilton product a*b, op 1 rotates vector b by the
// conjugate of a, op 2 gives the right, up and forward rows of a; op 3 returns
// all zeros. Each item passes from its input transfer to out_valid through the
// four register stages: first-level products, rounded sums with saturation,
// rotation products, and the final combine held in the output register.
// A new item is taken every cycle unless a stalled output has filled every
// stage; each stage advances when it is empty or the stage after it advances,
// so a stalled output only holds the stages that are full. Results of one
// item come back in one output transfer, in input order; saturated flags any
// clip, including the rotation intermediates.
module quaternion_rotation_unit_core import qru_pkg::*; #(
  parameter int unsigned COMP_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   op,
  input  logic signed [COMP_WIDTH-1:0] a_w,
  input  logic signed [COMP_WIDTH-1:0] a_x,
  input  logic signed [COMP_WIDTH-1:0] a_y,
  input  logic signed [COMP_WIDTH-1:0] a_z,
  input  logic signed [COMP_WIDTH-1:0] b_w,
  input  logic signed [COMP_WIDTH-1:0] b_x,
  input  logic signed [COMP_WIDTH-1:0] b_y,
  input  logic signed [COMP_WIDTH-1:0] b_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COMP_WIDTH-1:0] result_0,
  output logic signed [COMP_WIDTH-1:0] result_1,
  output logic signed [COMP_WIDTH-1:0] result_2,
  output logic signed [COMP_WIDTH-1:0] result_3,
  output logic signed [COMP_WIDTH-1:0] result_4,
  output logic signed [COMP_WIDTH-1:0] result_5,
  output logic signed [COMP_WIDTH-1:0] result_6,
  output logic signed [COMP_WIDTH-1:0] result_7,
  output logic signed [COMP_WIDTH-1:0] result_8,
  output logic                         saturated
);

  localparam int unsigned CW = COMP_WIDTH;

  logic en1, en2, en3, en4;
  qru_ctl_t in_ctl, s1_ctl, s2_ctl, s3_ctl, s4_ctl;

  logic signed [CW-1:0]   in_av [4];
  logic signed [CW-1:0]   in_bv [3];
  logic signed [2*CW-1:0] s1_prod [NPROD];
  logic signed [CW-1:0]   s1_av [4];
  logic signed [CW-1:0]   s1_bv [3];
  logic signed [CW-1:0]   s2_res [NRES];
  logic                   s2_clip;
  logic signed [CW-1:0]   s2_av [4];
  logic signed [CW-1:0]   s2_bv [3];
  logic signed [CW-1:0]   s3_res [NRES];
  logic                   s3_clip;
  logic signed [2*CW-1:0] s3_rprod [NROT];
  logic signed [CW-1:0]   s4_res [NRES];
  logic                   s4_clip;

  assign en4 = !s4_ctl.valid || out_ready;
  assign en3 = !s3_ctl.valid || en4;
  assign en2 = !s2_ctl.valid || en3;
  assign en1 = !s1_ctl.valid || en2;
  assign in_ready = en1;

  assign in_ctl = '{valid: in_valid, op: op_t'(op)};
  assign in_av[QW] = a_w;
  assign in_av[QX] = a_x;
  assign in_av[QY] = a_y;
  assign in_av[QZ] = a_z;
  assign in_bv[VX] = b_x;
  assign in_bv[VY] = b_y;
  assign in_bv[VZ] = b_z;

  qru_prod #(.CW(CW)) u_prod (
    .clk    (clk),
    .rst    (rst),
    .en     (en1),
    .ctl_in (in_ctl),
    .av_in  (in_av),
    .b_w    (b_w),
    .bv_in  (in_bv),
    .ctl    (s1_ctl),
    .prod   (s1_prod),
    .av     (s1_av),
    .bv     (s1_bv)
  );

  qru_sum #(.CW(CW), .FB(FRAC_BITS)) u_sum (
    .clk    (clk),
    .rst    (rst),
    .en     (en2),
    .ctl_in (s1_ctl),
    .prod   (s1_prod),
    .av_in  (s1_av),
    .bv_in  (s1_bv),
    .ctl    (s2_ctl),
    .res    (s2_res),
    .clip   (s2_clip),
    .av     (s2_av),
    .bv     (s2_bv)
  );

  qru_rot #(.CW(CW)) u_rot (
    .clk     (clk),
    .rst     (rst),
    .en      (en3),
    .ctl_in  (s2_ctl),
    .res_in  (s2_res),
    .clip_in (s2_clip),
    .av_in   (s2_av),
    .bv_in   (s2_bv),
    .ctl     (s3_ctl),
    .res     (s3_res),
    .clip    (s3_clip),
    .rprod   (s3_rprod)
  );

  qru_final #(.CW(CW), .FB(FRAC_BITS)) u_final (
    .clk     (clk),
    .rst     (rst),
    .en      (en4),
    .ctl_in  (s3_ctl),
    .res_in  (s3_res),
    .clip_in (s3_clip),
    .rprod   (s3_rprod),
    .ctl     (s4_ctl),
    .res     (s4_res),
    .clip    (s4_clip)
  );

  assign out_valid = s4_ctl.valid;
  assign result_0  = s4_res[0];
  assign result_1  = s4_res[1];
  assign result_2  = s4_res[2];
  assign result_3  = s4_res[3];
  assign result_4  = s4_res[4];
  assign result_5  = s4_res[5];
  assign result_6  = s4_res[6];
  assign result_7  = s4_res[7];
  assign result_8  = s4_res[8];
  assign saturated = s4_clip;

`ifndef ASSERT_OFF
  a_empty_front_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_ctl.valid |-> in_ready)
    else $error("input not ready while first stage is empty");

  a_stalled_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s2_ctl.valid && !en3 |=> s2_ctl.valid)
    else $error("stalled item dropped from second stage");

  a_rot_upper_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && s4_ctl.op == OP_ROT |->
      result_3 == 0 && result_4 == 0 && result_5 == 0 && result_6 == 0 &&
      result_7 == 0 && result_8 == 0)
    else $error("rotate result carries nonzero unused fields");

  a_unused_op_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && s4_ctl.op != OP_MUL && s4_ctl.op != OP_ROT && s4_ctl.op != OP_AXES |->
      !saturated && result_0 == 0 && result_1 == 0 && result_2 == 0 && result_3 == 0)
    else $error("unused op produced a nonzero result");
`endif

endmodule
